// File: hw/rtl/gmc_pkg.sv
// ----------------------------------------------------------------------------
// gmc_pkg
// Shared types and constants for the gate motor controller: state codes,
// fault codes, register indexes and the beat payloads.
// ----------------------------------------------------------------------------
package gmc_pkg;

  localparam int unsigned RUN_LIMIT_W = 16;
  localparam int unsigned SEP_W       = 10;
  localparam int unsigned RUN_CNT_W   = 17;
  localparam int unsigned CFG_IDX_W   = 2;
  localparam int unsigned CFG_DATA_W  = 16;

  localparam logic [RUN_LIMIT_W-1:0] RUN_LIMIT_RESET = 16'd12000;
  localparam logic [SEP_W-1:0]       SEP_TICKS_RESET = 10'd300;

  localparam logic [CFG_IDX_W-1:0] REG_RUN_TIME_LIMIT   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SEPARATION_TICKS = 2'd1;

  typedef enum logic [2:0] {
    MODE_INIT    = 3'd0,
    MODE_CLOSED  = 3'd1,
    MODE_OPEN    = 3'd2,
    MODE_CLOSING = 3'd3,
    MODE_OPENING = 3'd4,
    MODE_ERROR   = 3'd5
  } mode_t;

  typedef enum logic [1:0] {
    FAULT_NONE     = 2'd0,
    FAULT_SWITCHES = 2'd1,
    FAULT_RUN_TIME = 2'd2
  } fault_t;

  typedef struct packed {
    logic closed_switch;
    logic open_switch;
    logic button_pulse;
  } gmc_in_t;

  typedef struct packed {
    logic       motor_open;
    logic       motor_close;
    logic       led_opening;
    logic       led_closing;
    logic       led_fault;
    logic [2:0] gate_state;
    logic [1:0] fault_code;
  } gmc_out_t;

  typedef struct packed {
    logic [RUN_LIMIT_W-1:0] run_time_limit;
    logic [SEP_W-1:0]       separation_ticks;
  } gmc_cfg_t;

endpackage

// File: hw/rtl/gmc_cfg_regs.sv
// ----------------------------------------------------------------------------
// gmc_cfg_regs
// Configuration registers: run-time limit and separation ticks.
// ----------------------------------------------------------------------------
module gmc_cfg_regs (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [gmc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [gmc_pkg::CFG_DATA_W-1:0] cfg_data,
  output gmc_pkg::gmc_cfg_t             cfg
);
  import gmc_pkg::*;

  logic [RUN_LIMIT_W-1:0] run_limit_r;
  logic [SEP_W-1:0]       sep_ticks_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_limit_r <= RUN_LIMIT_RESET;
      sep_ticks_r <= SEP_TICKS_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_RUN_TIME_LIMIT:   run_limit_r <= cfg_data[RUN_LIMIT_W-1:0];
        REG_SEPARATION_TICKS: sep_ticks_r <= cfg_data[SEP_W-1:0];
        default: ;
      endcase
    end
  end

  assign cfg.run_time_limit   = run_limit_r;
  assign cfg.separation_ticks = sep_ticks_r;

endmodule

// File: hw/rtl/gmc_fsm.sv
// ----------------------------------------------------------------------------
// gmc_fsm
// Gate state machine with run and separation counters; one step per
// accepted tick beat, result formed from the state reached.
// ----------------------------------------------------------------------------
module gmc_fsm (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              step,
  input  gmc_pkg::gmc_in_t  in_beat,
  input  gmc_pkg::gmc_cfg_t cfg,
  output gmc_pkg::gmc_out_t res
);
  import gmc_pkg::*;

  mode_t                mode_r, mode_nxt;
  mode_t                prior_r, prior_nxt;
  logic [RUN_CNT_W-1:0] run_r, run_nxt;
  logic [SEP_W-1:0]     sep_r, sep_nxt;
  fault_t               fault_r, fault_nxt;

  logic                 target_sw;
  mode_t                done_mode;
  logic [RUN_CNT_W-1:0] run_inc;

  // next state
  always_comb begin
    mode_nxt  = mode_r;
    prior_nxt = prior_r;
    run_nxt   = run_r;
    sep_nxt   = sep_r;
    fault_nxt = fault_r;
    target_sw = (mode_r == MODE_CLOSING) ? in_beat.closed_switch : in_beat.open_switch;
    done_mode = (mode_r == MODE_CLOSING) ? MODE_CLOSED : MODE_OPEN;
    run_inc   = run_r + RUN_CNT_W'(1);
    case (mode_r)
      MODE_CLOSED: begin
        if (in_beat.button_pulse) begin
          prior_nxt = MODE_CLOSED;
          mode_nxt  = MODE_OPENING;
          run_nxt   = '0;
          sep_nxt   = '0;
        end
      end
      MODE_OPEN: begin
        if (in_beat.button_pulse) begin
          prior_nxt = MODE_OPEN;
          mode_nxt  = MODE_CLOSING;
          run_nxt   = '0;
          sep_nxt   = '0;
        end
      end
      MODE_CLOSING, MODE_OPENING: begin
        if (sep_r < cfg.separation_ticks) begin
          sep_nxt = sep_r + SEP_W'(1);
        end else if (target_sw) begin
          prior_nxt = mode_r;
          mode_nxt  = done_mode;
        end else begin
          run_nxt = run_inc;
          if (run_inc > {1'b0, cfg.run_time_limit}) begin
            fault_nxt = FAULT_RUN_TIME;
            prior_nxt = mode_r;
            mode_nxt  = MODE_ERROR;
          end
        end
      end
      MODE_ERROR: begin
        if (in_beat.button_pulse) begin
          fault_nxt = FAULT_NONE;
          prior_nxt = MODE_ERROR;
          if (prior_r == MODE_OPENING || prior_r == MODE_CLOSING) begin
            mode_nxt = prior_r;
            run_nxt  = '0;
            sep_nxt  = '0;
          end else begin
            mode_nxt = MODE_INIT;
          end
        end
      end
      default: begin
        // init, and any unused code behaves as init
        prior_nxt = MODE_INIT;
        fault_nxt = FAULT_NONE;
        if (in_beat.closed_switch && in_beat.open_switch) begin
          fault_nxt = FAULT_SWITCHES;
          mode_nxt  = MODE_ERROR;
        end else if (in_beat.closed_switch) begin
          mode_nxt = MODE_CLOSED;
        end else begin
          mode_nxt = MODE_CLOSING;
          run_nxt  = '0;
          sep_nxt  = '0;
        end
      end
    endcase
  end

  // outputs for the state reached
  always_comb begin
    res.motor_open  = (mode_nxt == MODE_OPENING);
    res.motor_close = (mode_nxt == MODE_CLOSING);
    res.led_opening = (mode_nxt == MODE_OPENING);
    res.led_closing = (mode_nxt == MODE_CLOSING);
    res.led_fault   = (mode_nxt == MODE_ERROR);
    res.gate_state  = mode_nxt;
    res.fault_code  = (mode_nxt == MODE_ERROR) ? fault_nxt : FAULT_NONE;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= MODE_INIT;
      prior_r <= MODE_INIT;
      run_r   <= '0;
      sep_r   <= '0;
      fault_r <= FAULT_NONE;
    end else if (step) begin
      mode_r  <= mode_nxt;
      prior_r <= prior_nxt;
      run_r   <= run_nxt;
      sep_r   <= sep_nxt;
      fault_r <= fault_nxt;
    end
  end

`ifndef NO_ASSERTIONS
  a_fault_only_in_error: assert property (@(posedge clk) disable iff (!rst_n)
    (mode_r == MODE_CLOSED || mode_r == MODE_OPEN) |-> (fault_r == FAULT_NONE))
    else $error("fault held outside error");
  a_step_to_error_flags: assert property (@(posedge clk) disable iff (!rst_n)
    (step && mode_nxt == MODE_ERROR && mode_r != MODE_ERROR) |=>
      (fault_r == FAULT_SWITCHES || fault_r == FAULT_RUN_TIME))
    else $error("error entered without a fault code");
  a_counters_clear_on_motion: assert property (@(posedge clk) disable iff (!rst_n)
    (step && mode_r != MODE_CLOSING && mode_r != MODE_OPENING &&
     (mode_nxt == MODE_CLOSING || mode_nxt == MODE_OPENING)) |=>
      (run_r == '0 && sep_r == '0))
    else $error("counters not cleared at motion start");
`endif

endmodule

// File: hw/rtl/gmc_out_buf.sv
// ----------------------------------------------------------------------------
// gmc_out_buf
// Result register with a skid stage, so an input beat is taken while a
// result still waits downstream.
// ----------------------------------------------------------------------------
module gmc_out_buf (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  gmc_pkg::gmc_out_t push_data,
  output logic              full,
  output logic              out_valid,
  input  logic              out_stall,
  output gmc_pkg::gmc_out_t out_data
);
  import gmc_pkg::*;

  logic     out_vld_r, out_vld_nxt;
  logic     skid_vld_r, skid_vld_nxt;
  gmc_out_t out_data_r, out_data_nxt;
  gmc_out_t skid_data_r, skid_data_nxt;
  logic     pop;

  assign pop = out_vld_r && !out_stall;

  always_comb begin
    out_vld_nxt   = out_vld_r;
    skid_vld_nxt  = skid_vld_r;
    out_data_nxt  = out_data_r;
    skid_data_nxt = skid_data_r;
    if (!out_vld_r || pop) begin
      if (skid_vld_r) begin
        out_data_nxt = skid_data_r;
        out_vld_nxt  = 1'b1;
        skid_vld_nxt = 1'b0;
      end else begin
        out_data_nxt = push_data;
        out_vld_nxt  = push;
      end
    end else if (push) begin
      skid_data_nxt = push_data;
      skid_vld_nxt  = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r  <= 1'b0;
      skid_vld_r <= 1'b0;
    end else begin
      out_vld_r  <= out_vld_nxt;
      skid_vld_r <= skid_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r  <= out_data_nxt;
    skid_data_r <= skid_data_nxt;
  end

  assign full      = skid_vld_r;
  assign out_valid = out_vld_r;
  assign out_data  = out_data_r;

`ifndef NO_ASSERTIONS
  a_skid_implies_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_vld_r |-> out_vld_r)
    else $error("skid holds a beat while result register is empty");
  a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    skid_vld_r |-> !push)
    else $error("beat pushed into full buffer");
  a_skid_drains_in_order: assert property (@(posedge clk) disable iff (!rst_n)
    (pop && skid_vld_r) |=> (out_vld_r && out_data_r == $past(skid_data_r)))
    else $error("skid beat not moved to result register");
`endif

endmodule

// File: hw/rtl/gate_motor_controller.sv
// ----------------------------------------------------------------------------
// gate_motor_controller
// Gate motor controller stepped once per tick beat.
//
//   channel  direction  handshake                payload
//   in_      input      in_valid / in_stall      gmc_in_t
//   out_     output     out_valid / out_stall    gmc_out_t
//   cfg_     input      cfg_valid / cfg_ready    cfg_index, cfg_data
//
// one beat per cycle in unless stalled; result registered, in the skid entry
// while the output stalls; the state step is compare and increment logic
// a two-entry result buffer raises in_stall only when both entries are full
// reset is synchronous and active low; restores all but data regs to defaults
// ----------------------------------------------------------------------------
module gate_motor_controller (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  gmc_pkg::gmc_in_t              in_data,
  output logic                          out_valid,
  input  logic                          out_stall,
  output gmc_pkg::gmc_out_t             out_data,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [gmc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [gmc_pkg::CFG_DATA_W-1:0] cfg_data
);
  import gmc_pkg::*;

  gmc_cfg_t cfg;
  gmc_out_t res;
  logic     full;
  logic     step;

  assign in_stall = full;
  assign step     = in_valid && !full;

  gmc_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  gmc_fsm u_fsm (
    .clk     (clk),
    .rst_n   (rst_n),
    .step    (step),
    .in_beat (in_data),
    .cfg     (cfg),
    .res     (res)
  );

  gmc_out_buf u_buf (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (step),
    .push_data (res),
    .full      (full),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

// File: verif/gmc_step_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gmc_step_checker
// Watches the tick, result and register channels of the gate motor
// controller. Keeps its own copy of the gate state machine and counters,
// works out the result of each accepted tick beat and compares every result
// beat, field by field, with the oldest outstanding prediction.
// ----------------------------------------------------------------------------
module gmc_step_checker (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  input  logic                           in_stall,
  input  gmc_pkg::gmc_in_t               in_data,
  input  logic                           out_valid,
  input  logic                           out_stall,
  input  gmc_pkg::gmc_out_t              out_data,
  input  logic                           cfg_valid,
  input  logic                           cfg_ready,
  input  logic [gmc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [gmc_pkg::CFG_DATA_W-1:0] cfg_data,
  output int unsigned                    mismatch_count,
  output int unsigned                    steps_in_flight
);
  import gmc_pkg::*;

  mode_t                  mode;
  mode_t                  mode_before;
  fault_t                 fault;
  logic [RUN_CNT_W-1:0]   run_ticks;
  logic [SEP_W-1:0]       sep_ticks;
  logic [RUN_LIMIT_W-1:0] run_limit;
  logic [SEP_W-1:0]       sep_limit;
  gmc_out_t               expected_steps[$];
  int unsigned            errors = 0;

  task automatic enter_mode(input mode_t nxt);
    mode_before = mode;
    mode = nxt;
    if (nxt == MODE_CLOSING || nxt == MODE_OPENING) begin
      run_ticks = '0;
      sep_ticks = '0;
    end
    if (nxt == MODE_INIT)
      fault = FAULT_NONE;
  endtask

  // one tick of motion: separation window first, then limit switch or run count
  task automatic travel_tick(input logic at_end, input mode_t done_mode);
    if (sep_ticks < sep_limit) begin
      sep_ticks = sep_ticks + 1'b1;
    end else if (at_end) begin
      enter_mode(done_mode);
    end else begin
      run_ticks = run_ticks + 1'b1;
      if (run_ticks > run_limit) begin
        fault = FAULT_RUN_TIME;
        enter_mode(MODE_ERROR);
      end
    end
  endtask

  task automatic step_gate(input gmc_in_t t, output gmc_out_t r);
    mode_t back;
    case (mode)
      MODE_CLOSED: if (t.button_pulse) enter_mode(MODE_OPENING);
      MODE_OPEN: if (t.button_pulse) enter_mode(MODE_CLOSING);
      MODE_CLOSING: travel_tick(t.closed_switch, MODE_CLOSED);
      MODE_OPENING: travel_tick(t.open_switch, MODE_OPEN);
      MODE_ERROR: begin
        if (t.button_pulse) begin
          back = mode_before;
          fault = FAULT_NONE;
          if (back == MODE_OPENING || back == MODE_CLOSING)
            enter_mode(back);
          else
            enter_mode(MODE_INIT);
        end
      end
      default: begin
        fault = FAULT_NONE;
        if (t.closed_switch && t.open_switch) begin
          fault = FAULT_SWITCHES;
          enter_mode(MODE_ERROR);
        end else if (t.closed_switch) begin
          enter_mode(MODE_CLOSED);
        end else begin
          enter_mode(MODE_CLOSING);
        end
        mode_before = MODE_INIT;
      end
    endcase
    r.motor_open  = (mode == MODE_OPENING);
    r.motor_close = (mode == MODE_CLOSING);
    r.led_opening = (mode == MODE_OPENING);
    r.led_closing = (mode == MODE_CLOSING);
    r.led_fault   = (mode == MODE_ERROR);
    r.gate_state  = mode;
    r.fault_code  = (mode == MODE_ERROR) ? fault : FAULT_NONE;
  endtask

  task automatic compare_field(input string field, input logic [2:0] want,
                               input logic [2:0] got);
    if (want !== got) begin
      $error("%s: expected %0d, actual %0d", field, want, got);
      errors++;
    end
  endtask

  always @(posedge clk) begin : watch
    gmc_out_t want;
    if (!rst_n) begin
      mode        = MODE_INIT;
      mode_before = MODE_INIT;
      fault       = FAULT_NONE;
      run_ticks   = '0;
      sep_ticks   = '0;
      run_limit   = RUN_LIMIT_RESET;
      sep_limit   = SEP_TICKS_RESET;
      expected_steps.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_steps.size() == 0) begin
          $error("result beat with no tick outstanding: %h", out_data);
          errors++;
        end else begin
          want = expected_steps.pop_front();
          compare_field("motor_open", want.motor_open, out_data.motor_open);
          compare_field("motor_close", want.motor_close, out_data.motor_close);
          compare_field("led_opening", want.led_opening, out_data.led_opening);
          compare_field("led_closing", want.led_closing, out_data.led_closing);
          compare_field("led_fault", want.led_fault, out_data.led_fault);
          compare_field("gate_state", want.gate_state, out_data.gate_state);
          compare_field("fault_code", want.fault_code, out_data.fault_code);
        end
      end
      if (in_valid && !in_stall) begin
        step_gate(in_data, want);
        expected_steps.push_back(want);
      end
      // new register values apply from the next tick
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_RUN_TIME_LIMIT: run_limit = cfg_data[RUN_LIMIT_W-1:0];
          REG_SEPARATION_TICKS: sep_limit = cfg_data[SEP_W-1:0];
          default: ;
        endcase
      end
    end
    mismatch_count  <= errors;
    steps_in_flight <= expected_steps.size();
  end

endmodule

// File: verif/tb_gate_motor_controller.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_gate_motor_controller
// Drives tick beats and register writes into the gate motor controller while
// the result side stalls at random. A short directed sequence walks the
// states, switch faults, run-time faults and resumes; random phases under
// several register settings, extremes included, follow. The checker beside
// the block predicts and compares; this module gives the verdict.
// ----------------------------------------------------------------------------
module tb_gate_motor_controller;
  import gmc_pkg::*;

  localparam int unsigned CYCLE_LIMIT    = 300000;
  localparam int unsigned LONG_HOLD      = 64;
  localparam int unsigned PHASES         = 6;
  localparam int unsigned PRESSURE_PHASE = 3;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 2'd3;

  typedef enum int unsigned {STALL_NONE, STALL_HALF, STALL_HEAVY} stall_style_t;

  logic                  clk;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_stall;
  gmc_in_t               in_data;
  logic                  out_valid;
  logic                  out_stall;
  gmc_out_t              out_data;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  int unsigned           mismatch_count;
  int unsigned           steps_in_flight;
  int unsigned           cycle_count = 0;
  int unsigned           burst_left = 0;
  bit                    back_to_back;
  bit                    hold_request;

  gate_motor_controller u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  gmc_step_checker u_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_data         (in_data),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_data        (out_data),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .mismatch_count  (mismatch_count),
    .steps_in_flight (steps_in_flight)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin : receiver
    int unsigned  span;
    stall_style_t style;
    out_stall <= 1'b0;
    forever begin
      if (hold_request) begin
        hold_request = 1'b0;
        repeat (LONG_HOLD) begin
          @(posedge clk);
          out_stall <= 1'b1;
        end
      end else begin
        span  = $urandom_range(1, 24);
        style = stall_style_t'($urandom_range(0, 2));
        repeat (span) begin
          @(posedge clk);
          case (style)
            STALL_NONE: out_stall <= 1'b0;
            STALL_HALF: out_stall <= ($urandom_range(0, 1) == 1);
            default: out_stall <= ($urandom_range(0, 3) != 0);
          endcase
        end
      end
    end
  end

  // bursts of beats with random gaps, unless back to back is asked for
  task automatic send_tick(input gmc_in_t t);
    int unsigned gap;
    in_valid <= 1'b1;
    in_data  <= t;
    do @(posedge clk); while (in_stall);
    if (back_to_back || burst_left > 0) begin
      if (burst_left > 0)
        burst_left--;
    end else begin
      in_valid <= 1'b0;
      gap = ($urandom_range(0, 7) == 0) ? $urandom_range(10, 30) : $urandom_range(1, 4);
      repeat (gap) @(posedge clk);
      burst_left = $urandom_range(0, 15);
    end
  endtask

  task automatic drain_steps();
    in_valid <= 1'b0;
    @(posedge clk);
    while (steps_in_flight != 0) @(posedge clk);
  endtask

  task automatic cfg_beat(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic write_regs(input logic [CFG_DATA_W-1:0] limit_word,
                            input logic [SEP_W-1:0] sep_value);
    cfg_beat(REG_RUN_TIME_LIMIT, limit_word);
    // upper bits beyond the field width are junk
    cfg_beat(REG_SEPARATION_TICKS, {6'($urandom), sep_value});
    cfg_beat(($urandom_range(0, 1) == 1) ? REG_SPARE_A : REG_SPARE_B, 16'($urandom));
    cfg_valid <= 1'b0;
  endtask

  function automatic gmc_in_t random_tick();
    gmc_in_t t;
    t.closed_switch = ($urandom_range(0, 99) < 30);
    t.open_switch   = ($urandom_range(0, 99) < 30);
    t.button_pulse  = ($urandom_range(0, 99) < 35);
    return t;
  endfunction

  initial begin : stimulus
    logic [CFG_DATA_W-1:0] limit_words[PHASES] = '{16'd5, 16'd1, 16'hFFFF, 16'd2, 16'd0, 16'd0};
    logic [SEP_W-1:0]      sep_values[PHASES]  = '{10'd3, 10'd0, 10'h3FF, 10'd1, 10'd0, 10'd0};
    int unsigned           phase_len[PHASES]   = '{130, 90, 40, 130, 80, 210};
    in_valid  <= 1'b0;
    in_data   <= '0;
    cfg_valid <= 1'b0;
    cfg_index <= REG_RUN_TIME_LIMIT;
    cfg_data  <= '0;
    rst_n     <= 1'b0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // reset settings: switch fault, resume to init, long separation window
    send_tick('{1'b1, 1'b1, 1'b0});
    send_tick('{1'b0, 1'b0, 1'b0});
    send_tick('{1'b1, 1'b1, 1'b1});
    send_tick('{1'b1, 1'b0, 1'b1});
    send_tick('{1'b0, 1'b1, 1'b0});
    send_tick('{1'b1, 1'b1, 1'b1});
    send_tick('{1'b0, 1'b1, 1'b1});
    send_tick('{1'b1, 1'b1, 1'b0});
    drain_steps();

    // zero run limit and no separation: fault on the first counted tick
    write_regs(16'd0, 10'd0);
    send_tick('{1'b0, 1'b0, 1'b0});
    send_tick('{1'b0, 1'b1, 1'b1});
    send_tick('{1'b0, 1'b1, 1'b0});
    send_tick('{1'b0, 1'b0, 1'b0});
    send_tick('{1'b1, 1'b0, 1'b1});
    send_tick('{1'b1, 1'b0, 1'b1});
    send_tick('{1'b0, 1'b0, 1'b1});
    send_tick('{1'b1, 1'b0, 1'b0});
    drain_steps();

    write_regs(16'd3, 10'd2);
    send_tick('{1'b0, 1'b0, 1'b1});
    send_tick('{1'b0, 1'b1, 1'b0});
    send_tick('{1'b0, 1'b1, 1'b0});
    send_tick('{1'b0, 1'b0, 1'b0});
    send_tick('{1'b0, 1'b0, 1'b1});
    send_tick('{1'b0, 1'b1, 1'b0});

    limit_words[PHASES-1] = 16'($urandom_range(1, 12));
    sep_values[PHASES-1]  = 10'($urandom_range(0, 8));
    for (int ph = 0; ph < PHASES; ph++) begin
      drain_steps();
      write_regs(limit_words[ph], sep_values[ph]);
      if (ph == PRESSURE_PHASE) begin
        hold_request = 1'b1;
        back_to_back = 1'b1;
      end
      for (int k = 0; k < phase_len[ph]; k++) begin
        send_tick(random_tick());
        if (k == 80)
          back_to_back = 1'b0;
      end
    end

    drain_steps();
    repeat (8) @(posedge clk);
    if (mismatch_count == 0 && steps_in_flight == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end

endmodule

// File: gate_motor_controller.f
hw/rtl/gmc_pkg.sv
hw/rtl/gmc_cfg_regs.sv
hw/rtl/gmc_fsm.sv
hw/rtl/gmc_out_buf.sv
hw/rtl/gate_motor_controller.sv
verif/gmc_step_checker.sv
verif/tb_gate_motor_controller.sv
